>>> hdl/mp2d_pkg.sv
`timescale 1ns / 1ps
package mp2d_pkg;
   localparam int MAX_DIM     = 64;
   localparam int PLANE_DEPTH = 4096;
   localparam int ADDR_W      = 12;
   localparam int DIM_W       = 7;
   localparam int POS_W       = 12;
   localparam int CSR_IDX_W   = 3;

   localparam logic [31:0]       NEG_INF_BITS = 32'hFF80_0000;
   localparam logic [ADDR_W-1:0] INDEX_SAT    = 12'hFFF;

   localparam logic [CSR_IDX_W-1:0] REG_KERNEL   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STRIDE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PADDING  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DILATION = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT   = 3'd5;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PREP, ST_ADJ, ST_BASE, ST_SCAN, ST_DRAIN, ST_DONE
   } state_type;

   typedef struct packed {
      logic init;
      logic upd;
   } best_ctrl_type;

   function automatic logic is_nan(input logic [31:0] b);
      return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
   endfunction

   function automatic logic [31:0] order_key(input logic [31:0] b);
      logic [31:0] t;
      t = (b[30:0] == 31'd0) ? 32'd0 : b;
      return t[31] ? ~t : (t | 32'h8000_0000);
   endfunction

   function automatic logic [3:0] nib_one(input logic [3:0] n);
      return (n == 4'd0) ? 4'd1 : n;
   endfunction

   function automatic logic [DIM_W-1:0] dim_of(input logic [DIM_W-1:0] n);
      logic [DIM_W-1:0] t;
      t = (n == '0) ? DIM_W'(1) : n;
      return (t > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : t;
   endfunction
endpackage

>>> hdl/mp2d_ram.sv
`timescale 1ns / 1ps
module mp2d_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

>>> hdl/mp2d_best.sv
`timescale 1ns / 1ps
module mp2d_best (
   input  logic                           clock,
   input  mp2d_pkg::best_ctrl_type        ctrl,
   input  logic [mp2d_pkg::ADDR_W-1:0]    init_idx,
   input  logic [31:0]                    pix_value,
   input  logic [mp2d_pkg::ADDR_W-1:0]    pix_idx,
   output logic [31:0]                    best_value,
   output logic [mp2d_pkg::ADDR_W-1:0]    best_idx
);
   import mp2d_pkg::*;

   logic [31:0]       val_ff, val_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic              take;

   // A NaN always wins, even over a NaN already held; nothing else beats a held NaN.
   assign take = is_nan(pix_value) ||
                 (!is_nan(val_ff) && (order_key(pix_value) > order_key(val_ff)));

   always_comb begin
      val_in = val_ff;
      idx_in = idx_ff;
      if (ctrl.init) begin
         val_in = NEG_INF_BITS;
         idx_in = init_idx;
      end else if (ctrl.upd && take) begin
         val_in = pix_value;
         idx_in = pix_idx;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      idx_ff <= idx_in;
   end

   assign best_value = val_ff;
   assign best_idx   = idx_ff;
endmodule

>>> hdl/max_pool2d_with_argmax.sv
`timescale 1ns / 1ps
// Max pooling with argmax over one stored plane of single-precision pixels.
// Items enter on start while busy is low. A load item (req_action low) writes
// one pixel into the plane memory in the accepting cycle and gives no result;
// the block stays free, so loads can follow back to back.
// A query item (req_action high) raises busy until its result has been shown.
// The block finds the clipped window, steps negative start positions forward
// (one dilation step a cycle), then reads the plane memory one window element
// per cycle and compares each pixel in the cycle after its read. An empty
// window answers with empty_window set. The result shows for one cycle with
// rsp_valid; the receiver cannot stall. Configuration writes on the csr_
// channel are always ready; the user must keep them to idle periods, and the
// block does not enforce this. Reset (synchronous) restores the register
// defaults and idles the block; the plane memory is not cleared and holds
// whatever it held, so pixels must be loaded before a query reads them.
module max_pool2d_with_argmax (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_action,
   input  logic [mp2d_pkg::ADDR_W-1:0]       req_pixel_index,
   input  logic [31:0]                       req_pixel_value,
   input  logic [5:0]                        req_out_row,
   input  logic [5:0]                        req_out_col,
   output logic                              rsp_valid,
   output logic [31:0]                       rsp_max_value,
   output logic [mp2d_pkg::ADDR_W-1:0]       rsp_max_index,
   output logic                              rsp_empty_window,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mp2d_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [7:0]                        csr_data
);
   import mp2d_pkg::*;

   state_type state_ff, state_in;

   logic [7:0]       kernel_ff, stride_ff, padding_ff, dilation_ff;
   logic [DIM_W-1:0] width_ff, height_ff;

   logic [5:0] row_q_ff, col_q_ff;
   logic signed [POS_W-1:0] h0_ff, h0_in, w0_ff, w0_in, h1_ff, h1_in, w1_ff, w1_in;
   logic signed [POS_W-1:0] r_ff, r_in, c_ff, c_in;
   logic [ADDR_W-1:0] rbase_ff, rbase_in, rstep_ff, rstep_in;
   logic [DIM_W-1:0]  wid_ff, wid_in;
   logic [3:0]        dh_ff, dh_in, dw_ff, dw_in;
   logic              empty_ff, empty_in;
   logic              pv_ff, pv_in;
   logic [ADDR_W-1:0] pidx_ff, pidx_in;

   logic accept, load_acc, query_acc, csr_acc;
   logic [ADDR_W-1:0] rd_addr, init_idx;
   logic [31:0]       rd_data, best_value;
   logic [ADDR_W-1:0] best_idx;
   logic              rd_en;
   logic              row_end, last_elem;
   best_ctrl_type     bctrl;

   // Window geometry from the registers.
   logic [3:0] kw, kh, sw, sh, pw, ph;
   logic [DIM_W-1:0] hei;
   logic signed [POS_W-1:0] h0_calc, w0_calc;
   logic signed [POS_W-1:0] h1_calc, w1_calc;

   assign accept    = start && !busy;
   assign load_acc  = accept && (req_action == ACT_LOAD);
   assign query_acc = accept && (req_action == ACT_QUERY);
   assign csr_ready = 1'b1;
   assign csr_acc   = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff   <= 8'h22;
         stride_ff   <= 8'h22;
         padding_ff  <= 8'h00;
         dilation_ff <= 8'h11;
         width_ff    <= DIM_W'(MAX_DIM);
         height_ff   <= DIM_W'(MAX_DIM);
      end else if (csr_acc) begin
         case (csr_index)
            REG_KERNEL:   kernel_ff   <= csr_data;
            REG_STRIDE:   stride_ff   <= csr_data;
            REG_PADDING:  padding_ff  <= csr_data;
            REG_DILATION: dilation_ff <= csr_data;
            REG_WIDTH:    width_ff    <= csr_data[DIM_W-1:0];
            REG_HEIGHT:   height_ff   <= csr_data[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   assign kw  = nib_one(kernel_ff[3:0]);
   assign kh  = nib_one(kernel_ff[7:4]);
   assign sw  = nib_one(stride_ff[3:0]);
   assign sh  = nib_one(stride_ff[7:4]);
   assign pw  = padding_ff[3:0];
   assign ph  = padding_ff[7:4];
   assign hei = dim_of(height_ff);

   assign h0_calc = $signed(POS_W'(row_q_ff) * POS_W'(sh)) - $signed(POS_W'(ph));
   assign w0_calc = $signed(POS_W'(col_q_ff) * POS_W'(sw)) - $signed(POS_W'(pw));
   always_comb begin
      h1_calc = h0_calc
                + $signed(POS_W'(kh - 4'd1) * POS_W'(nib_one(dilation_ff[7:4])))
                + POS_W'(1);
      w1_calc = w0_calc
                + $signed(POS_W'(kw - 4'd1) * POS_W'(nib_one(dilation_ff[3:0])))
                + POS_W'(1);
      if (h1_calc > $signed(POS_W'(hei))) h1_calc = $signed(POS_W'(hei));
      if (w1_calc > $signed(POS_W'(dim_of(width_ff))))
         w1_calc = $signed(POS_W'(dim_of(width_ff)));
   end

   assign row_end   = (c_ff + $signed(POS_W'(dw_ff))) >= w1_ff;
   assign last_elem = row_end && ((r_ff + $signed(POS_W'(dh_ff))) >= h1_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (query_acc) state_in = ST_PREP;
         ST_PREP:  state_in = ST_ADJ;
         ST_ADJ:   if (!h0_ff[POS_W-1] && !w0_ff[POS_W-1]) state_in = ST_BASE;
         ST_BASE:  state_in = ((h0_ff >= h1_ff) || (w0_ff >= w1_ff)) ? ST_DONE : ST_SCAN;
         ST_SCAN:  if (last_elem) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_DONE;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs per state.
   always_comb begin
      h0_in    = h0_ff;
      w0_in    = w0_ff;
      h1_in    = h1_ff;
      w1_in    = w1_ff;
      r_in     = r_ff;
      c_in     = c_ff;
      rbase_in = rbase_ff;
      rstep_in = rstep_ff;
      wid_in   = wid_ff;
      dh_in    = dh_ff;
      dw_in    = dw_ff;
      empty_in = empty_ff;
      pv_in    = 1'b0;
      pidx_in  = pidx_ff;
      rd_en    = 1'b0;
      bctrl    = '0;
      busy     = (state_ff != ST_IDLE);
      rd_addr  = rbase_ff + ADDR_W'(c_ff);
      init_idx = ADDR_W'(h0_ff[5:0]) * ADDR_W'(wid_ff) + ADDR_W'(w0_ff);
      case (state_ff)
         ST_PREP: begin
            h0_in    = h0_calc;
            w0_in    = w0_calc;
            h1_in    = h1_calc;
            w1_in    = w1_calc;
            wid_in   = dim_of(width_ff);
            dh_in    = nib_one(dilation_ff[7:4]);
            dw_in    = nib_one(dilation_ff[3:0]);
            empty_in = 1'b0;
         end
         ST_ADJ: begin
            if (h0_ff[POS_W-1]) h0_in = h0_ff + $signed(POS_W'(dh_ff));
            if (w0_ff[POS_W-1]) w0_in = w0_ff + $signed(POS_W'(dw_ff));
         end
         ST_BASE: begin
            r_in       = h0_ff;
            c_in       = w0_ff;
            rbase_in   = ADDR_W'(h0_ff[5:0]) * ADDR_W'(wid_ff);
            rstep_in   = ADDR_W'(dh_ff) * ADDR_W'(wid_ff);
            bctrl.init = 1'b1;
            empty_in   = (h0_ff >= h1_ff) || (w0_ff >= w1_ff);
         end
         ST_SCAN: begin
            rd_en      = 1'b1;
            pv_in      = 1'b1;
            pidx_in    = rd_addr;
            bctrl.upd  = pv_ff;
            if (row_end) begin
               c_in     = w0_ff;
               r_in     = r_ff + $signed(POS_W'(dh_ff));
               rbase_in = rbase_ff + rstep_ff;
            end else begin
               c_in = c_ff + $signed(POS_W'(dw_ff));
            end
         end
         ST_DRAIN: bctrl.upd = pv_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         pv_ff    <= pv_in;
      end
      if (query_acc) begin
         row_q_ff <= req_out_row;
         col_q_ff <= req_out_col;
      end
      h0_ff    <= h0_in;
      w0_ff    <= w0_in;
      h1_ff    <= h1_in;
      w1_ff    <= w1_in;
      r_ff     <= r_in;
      c_ff     <= c_in;
      rbase_ff <= rbase_in;
      rstep_ff <= rstep_in;
      wid_ff   <= wid_in;
      dh_ff    <= dh_in;
      dw_ff    <= dw_in;
      empty_ff <= empty_in;
      pidx_ff  <= pidx_in;
   end

   mp2d_ram #(.WIDTH(32), .DEPTH(PLANE_DEPTH)) u_plane (
      .clock   (clock),
      .wr_en   (load_acc),
      .wr_addr (req_pixel_index),
      .wr_data (req_pixel_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mp2d_best u_best (
      .clock      (clock),
      .ctrl       (bctrl),
      .init_idx   (init_idx),
      .pix_value  (rd_data),
      .pix_idx    (pidx_ff),
      .best_value (best_value),
      .best_idx   (best_idx)
   );

   assign rsp_valid        = (state_ff == ST_DONE);
   assign rsp_empty_window = empty_ff;
   assign rsp_max_value    = empty_ff ? NEG_INF_BITS : best_value;
   assign rsp_max_index    = empty_ff ? INDEX_SAT : best_idx;

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      query_acc |=> busy && !rsp_valid)
      else $error("query accepted but block not busy");
   a_empty_neg_inf: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_window) |-> (rsp_max_value == NEG_INF_BITS))
      else $error("empty window without minus infinity");
   a_no_read_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !rd_en)
      else $error("plane read while idle");
endmodule
